// File: rtl/cqr_pkg.sv
// Package for the circular queue with readout.
// Holds sizes, operation and status codes, the sequencer state type and an index helper.
// No dependencies.
package cqr_pkg;

  localparam int DEPTH     = 16;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 5;
  localparam int CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  localparam logic [1:0] OP_ENQ     = 2'd0;
  localparam logic [1:0] OP_DEQ     = 2'd1;
  localparam logic [1:0] OP_READOUT = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_SCAN
  } seq_state_t;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == IDX_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + IDX_W'(1);
    end
    return r;
  endfunction

endpackage

// File: rtl/cqr_slot_ram.sv
// Slot storage of the circular queue: one write port and one registered read port.
// Depends on cqr_pkg for depth and word width.
module cqr_slot_ram (
  input  logic                             clk,
  input  logic                             we,
  input  logic [cqr_pkg::IDX_W-1:0]        waddr,
  input  logic signed [cqr_pkg::DATA_W-1:0] wdata,
  input  logic                             re,
  input  logic [cqr_pkg::IDX_W-1:0]        raddr,
  output logic signed [cqr_pkg::DATA_W-1:0] rdata
);

  logic signed [cqr_pkg::DATA_W-1:0] mem [cqr_pkg::DEPTH];
  logic signed [cqr_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/circular_queue_with_readout_top.sv
// Circular queue of signed words with a settable capacity and a full readout.
// Depends on cqr_pkg and cqr_slot_ram.
//
// Enqueue and dequeue may be issued every cycle when no readout is running; busy stays low.
// A readout returns the stored elements from head to tail, one element per cycle from the single
// read port of the slot memory, and holds busy high until the last element is read. Every result
// appears on the out_ ports in the cycle after it is produced, for exactly one cycle with
// out_valid high; the receiver cannot stall, so it must take each
// result when it is shown. The capacity register may only be written while the block is idle.
module circular_queue_with_readout_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_opcode,
  input  logic signed [cqr_pkg::DATA_W-1:0] in_data_value,
  input  logic                              cfg_wr_en,
  input  logic [cqr_pkg::CFG_W-1:0]         cfg_capacity_in_use,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic signed [cqr_pkg::DATA_W-1:0] out_data_out,
  output logic                              out_last
);

  cqr_pkg::seq_state_t state_r, state_nxt;

  logic [cqr_pkg::IDX_W-1:0] head_r, head_nxt;
  logic [cqr_pkg::IDX_W-1:0] tail_r, tail_nxt;
  logic [cqr_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [cqr_pkg::IDX_W-1:0] ptr_r, ptr_nxt;
  logic [cqr_pkg::CNT_W-1:0] left_r, left_nxt;
  logic [cqr_pkg::CFG_W-1:0] cap_r;

  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_mem_r, out_mem_nxt;

  logic                              accept;
  logic [cqr_pkg::CMP_W-1:0]         cap_ext;
  logic [cqr_pkg::CMP_W-1:0]         eff_cap;
  logic [cqr_pkg::CMP_W-1:0]         count_ext;
  logic                              we;
  logic [cqr_pkg::IDX_W-1:0]         waddr;
  logic                              re;
  logic [cqr_pkg::IDX_W-1:0]         raddr;
  logic signed [cqr_pkg::DATA_W-1:0] rdata;

  cqr_slot_ram u_slot_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_data_value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign accept    = start & ~busy;
  assign cap_ext   = cqr_pkg::CMP_W'(cap_r);
  assign count_ext = cqr_pkg::CMP_W'(count_r);

  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = cqr_pkg::CMP_W'(1);
    end else if (cap_ext > cqr_pkg::CMP_W'(cqr_pkg::DEPTH)) begin
      eff_cap = cqr_pkg::CMP_W'(cqr_pkg::DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cqr_pkg::SEQ_IDLE: begin
        if (accept && in_opcode == cqr_pkg::OP_READOUT &&
            count_r > cqr_pkg::CNT_W'(1)) begin
          state_nxt = cqr_pkg::SEQ_SCAN;
        end
      end
      cqr_pkg::SEQ_SCAN: begin
        if (left_r == cqr_pkg::CNT_W'(1)) begin
          state_nxt = cqr_pkg::SEQ_IDLE;
        end
      end
      default: state_nxt = cqr_pkg::SEQ_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_r == cqr_pkg::SEQ_SCAN);
  end

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    left_nxt       = left_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = cqr_pkg::ST_OK;
    out_last_nxt   = 1'b1;
    out_mem_nxt    = 1'b0;
    we             = 1'b0;
    waddr          = tail_r;
    re             = 1'b0;
    raddr          = head_r;

    if (state_r == cqr_pkg::SEQ_SCAN) begin
      re            = 1'b1;
      raddr         = ptr_r;
      out_valid_nxt = 1'b1;
      out_mem_nxt   = 1'b1;
      out_last_nxt  = (left_r == cqr_pkg::CNT_W'(1));
      ptr_nxt       = cqr_pkg::next_idx(ptr_r);
      left_nxt      = left_r - cqr_pkg::CNT_W'(1);
    end else if (accept) begin
      case (in_opcode)
        cqr_pkg::OP_ENQ: begin
          out_valid_nxt = 1'b1;
          if (count_ext >= eff_cap) begin
            out_status_nxt = cqr_pkg::ST_OVERFLOW;
          end else begin
            if (count_r != '0) begin
              tail_nxt = cqr_pkg::next_idx(tail_r);
            end else begin
              head_nxt = '0;
              tail_nxt = '0;
            end
            waddr     = tail_nxt;
            we        = 1'b1;
            count_nxt = count_r + cqr_pkg::CNT_W'(1);
          end
        end
        cqr_pkg::OP_DEQ: begin
          out_valid_nxt = 1'b1;
          if (count_r == '0) begin
            out_status_nxt = cqr_pkg::ST_UNDERFLOW;
          end else begin
            re          = 1'b1;
            out_mem_nxt = 1'b1;
            count_nxt   = count_r - cqr_pkg::CNT_W'(1);
            if (count_r == cqr_pkg::CNT_W'(1)) begin
              head_nxt = '0;
              tail_nxt = '0;
            end else begin
              head_nxt = cqr_pkg::next_idx(head_r);
            end
          end
        end
        cqr_pkg::OP_READOUT: begin
          out_valid_nxt = 1'b1;
          if (count_r == '0) begin
            out_status_nxt = cqr_pkg::ST_EMPTY;
          end else begin
            re           = 1'b1;
            out_mem_nxt  = 1'b1;
            out_last_nxt = (count_r == cqr_pkg::CNT_W'(1));
            ptr_nxt      = cqr_pkg::next_idx(head_r);
            left_nxt     = count_r - cqr_pkg::CNT_W'(1);
          end
        end
        default: begin
          out_valid_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cqr_pkg::SEQ_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      ptr_r       <= '0;
      left_r      <= '0;
      cap_r       <= cqr_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_capacity_in_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
    out_mem_r    <= out_mem_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_last     = out_last_r;
  assign out_data_out = out_mem_r ? rdata : '0;

endmodule

// File: tb/tb.sv
// Self-checking testbench for circular_queue_with_readout_top.
// Runs a directed table and then random items, and compares each result with a queue model.
// Depends on cqr_pkg and the RTL of the block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = cqr_pkg::DEPTH + 4;

  typedef struct {
    logic [1:0]                        status;
    logic signed [cqr_pkg::DATA_W-1:0] data;
    logic                              last;
  } qresult_t;

  typedef struct {
    logic [1:0]                        op;
    logic signed [cqr_pkg::DATA_W-1:0] word;
    bit                                typed;
    logic [1:0]                        status;
    logic signed [cqr_pkg::DATA_W-1:0] data;
  } table_row_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic [1:0]                        in_opcode = cqr_pkg::OP_ENQ;
  logic signed [cqr_pkg::DATA_W-1:0] in_data_value = '0;
  logic                              cfg_wr_en = 1'b0;
  logic [cqr_pkg::CFG_W-1:0]         cfg_capacity_in_use = cqr_pkg::CAP_RESET;
  logic                              out_valid;
  logic [1:0]                        out_status;
  logic signed [cqr_pkg::DATA_W-1:0] out_data_out;
  logic                              out_last;

  // Directed rows may carry a typed expectation for their single result.
  bit                                row_typed = 1'b0;
  logic [1:0]                        row_status = cqr_pkg::ST_OK;
  logic signed [cqr_pkg::DATA_W-1:0] row_data = '0;

  logic signed [cqr_pkg::DATA_W-1:0] model_slots [cqr_pkg::DEPTH];
  logic [cqr_pkg::IDX_W-1:0]         model_head = '0;
  logic [cqr_pkg::IDX_W-1:0]         model_tail = '0;
  int                                model_count = 0;
  logic [cqr_pkg::CFG_W-1:0]         model_cap = cqr_pkg::CAP_RESET;
  qresult_t                          queue_results [$];

  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int cycles = 0;
  table_row_t dir_rows [$];

  circular_queue_with_readout_top u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_opcode           (in_opcode),
    .in_data_value       (in_data_value),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_capacity_in_use (cfg_capacity_in_use),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_data_out        (out_data_out),
    .out_last            (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               queue_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void push_result(input logic [1:0] st,
                                      input logic signed [cqr_pkg::DATA_W-1:0] d,
                                      input logic lst);
    qresult_t r;
    r.status = st;
    r.data = d;
    r.last = lst;
    queue_results.push_back(r);
  endfunction

  function automatic logic [cqr_pkg::IDX_W-1:0] wrap_inc(input logic [cqr_pkg::IDX_W-1:0] i);
    return cqr_pkg::IDX_W'((int'(i) + 1) % cqr_pkg::DEPTH);
  endfunction

  function automatic void predict_queue_op(input logic [1:0] op,
                                           input logic signed [cqr_pkg::DATA_W-1:0] word);
    int limit;
    int k;
    logic [cqr_pkg::IDX_W-1:0] idx;
    logic signed [cqr_pkg::DATA_W-1:0] v;
    limit = int'(model_cap);
    if (limit < 1) limit = 1;
    if (limit > cqr_pkg::DEPTH) limit = cqr_pkg::DEPTH;
    case (op)
      cqr_pkg::OP_ENQ: begin
        if (model_count >= limit) begin
          push_result(cqr_pkg::ST_OVERFLOW, '0, 1'b1);
        end else begin
          if (model_count != 0) begin
            model_tail = wrap_inc(model_tail);
          end else begin
            model_head = '0;
            model_tail = '0;
          end
          model_slots[model_tail] = word;
          model_count++;
          push_result(cqr_pkg::ST_OK, '0, 1'b1);
        end
      end
      cqr_pkg::OP_DEQ: begin
        if (model_count == 0) begin
          push_result(cqr_pkg::ST_UNDERFLOW, '0, 1'b1);
        end else begin
          v = model_slots[model_head];
          model_count--;
          if (model_count == 0) begin
            model_head = '0;
            model_tail = '0;
          end else begin
            model_head = wrap_inc(model_head);
          end
          push_result(cqr_pkg::ST_OK, v, 1'b1);
        end
      end
      cqr_pkg::OP_READOUT: begin
        if (model_count == 0) begin
          push_result(cqr_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          idx = model_head;
          for (k = 0; k < model_count; k++) begin
            push_result(cqr_pkg::ST_OK, model_slots[idx], (k + 1 == model_count));
            idx = wrap_inc(idx);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin : monitor
    qresult_t want;
    if (rst_n) begin
      if (cfg_wr_en) model_cap = cfg_capacity_in_use;
      if (start && !busy) begin
        predict_queue_op(in_opcode, in_data_value);
        if (row_typed) begin
          want = queue_results.pop_back();
          want.status = row_status;
          want.data = row_data;
          queue_results.push_back(want);
        end
      end
      if (out_valid) begin
        results_checked++;
        if (queue_results.size() == 0) begin
          $error("Unexpected result: status %0d data %0d last %0d", out_status,
                 out_data_out, out_last);
          errors++;
        end else begin
          want = queue_results.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errors++;
          end
          if (out_data_out !== want.data) begin
            $error("data_out: expected %0d, got %0d", want.data, out_data_out);
            errors++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_last);
            errors++;
          end
        end
      end
    end
  end

  task automatic idle_cycles(input bit allow);
    if (allow) begin
      while ($urandom_range(99) < 26) begin
        start = 1'b0;
        in_opcode = 2'($urandom);
        in_data_value = $urandom;
        @(negedge clk);
      end
    end
  endtask

  task automatic send_item(input logic [1:0] op,
                           input logic signed [cqr_pkg::DATA_W-1:0] word,
                           input bit allow_idle);
    idle_cycles(allow_idle);
    start = 1'b1;
    in_opcode = op;
    in_data_value = word;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op != OP_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_results_drained(input bit settle);
    start = 1'b0;
    while (queue_results.size() != 0) @(negedge clk);
    if (settle) repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [cqr_pkg::CFG_W-1:0] cap);
    wait_results_drained(1'b1);
    cfg_wr_en = 1'b1;
    cfg_capacity_in_use = cap;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic table_row_t row(input logic [1:0] op,
                                     input logic signed [cqr_pkg::DATA_W-1:0] w,
                                     input bit typed, input logic [1:0] st,
                                     input logic signed [cqr_pkg::DATA_W-1:0] d);
    table_row_t r;
    r.op = op;
    r.word = w;
    r.typed = typed;
    r.status = st;
    r.data = d;
    return r;
  endfunction

  function automatic logic signed [cqr_pkg::DATA_W-1:0] random_word();
    logic signed [cqr_pkg::DATA_W-1:0] w;
    case ($urandom_range(15))
      0: w = 32'h7FFF_FFFF;
      1: w = 32'h8000_0000;
      2: w = '0;
      3: w = '1;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // Fill phases favor enqueue, drain phases favor dequeue.
  function automatic logic [1:0] random_op(input int bias);
    int p;
    logic [1:0] op;
    p = $urandom_range(99);
    if (p < 3) op = OP_UNUSED;
    else if (p < 20) op = cqr_pkg::OP_READOUT;
    else if (p < 20 + (bias == 1 ? 62 : bias == 2 ? 22 : 40)) op = cqr_pkg::OP_ENQ;
    else op = cqr_pkg::OP_DEQ;
    return op;
  endfunction

  initial begin : stimulus
    int i;
    int j;
    int n;
    logic [1:0] op;
    logic [cqr_pkg::CFG_W-1:0] phase_cap [8];
    int phase_bias [8];
    int phase_len [8];
    bit phase_idle [8];

    dir_rows.push_back(row(cqr_pkg::OP_READOUT, '0, 1, cqr_pkg::ST_EMPTY, '0));
    dir_rows.push_back(row(cqr_pkg::OP_DEQ, 32'h1234_5678, 1, cqr_pkg::ST_UNDERFLOW, '0));
    dir_rows.push_back(row(OP_UNUSED, 32'hFFFF_FFFF, 0, cqr_pkg::ST_OK, '0));
    dir_rows.push_back(row(cqr_pkg::OP_ENQ, 32'h7FFF_FFFF, 1, cqr_pkg::ST_OK, '0));
    dir_rows.push_back(row(cqr_pkg::OP_ENQ, 32'h8000_0000, 1, cqr_pkg::ST_OK, '0));
    dir_rows.push_back(row(cqr_pkg::OP_ENQ, 32'hFFFF_FFFF, 1, cqr_pkg::ST_OK, '0));
    dir_rows.push_back(row(cqr_pkg::OP_ENQ, 32'h0000_0000, 1, cqr_pkg::ST_OK, '0));
    dir_rows.push_back(row(cqr_pkg::OP_READOUT, 32'hFFFF_FFFF, 0, cqr_pkg::ST_OK, '0));
    dir_rows.push_back(row(cqr_pkg::OP_DEQ, '0, 1, cqr_pkg::ST_OK, 32'h7FFF_FFFF));
    dir_rows.push_back(row(cqr_pkg::OP_DEQ, '1, 1, cqr_pkg::ST_OK, 32'h8000_0000));
    dir_rows.push_back(row(OP_UNUSED, '0, 0, cqr_pkg::ST_OK, '0));
    dir_rows.push_back(row(cqr_pkg::OP_READOUT, '0, 0, cqr_pkg::ST_OK, '0));
    dir_rows.push_back(row(cqr_pkg::OP_DEQ, '0, 1, cqr_pkg::ST_OK, 32'hFFFF_FFFF));
    dir_rows.push_back(row(cqr_pkg::OP_DEQ, '0, 1, cqr_pkg::ST_OK, 32'h0000_0000));
    dir_rows.push_back(row(cqr_pkg::OP_DEQ, '0, 1, cqr_pkg::ST_UNDERFLOW, '0));
    dir_rows.push_back(row(cqr_pkg::OP_ENQ, 32'h5555_5555, 1, cqr_pkg::ST_OK, '0));
    dir_rows.push_back(row(cqr_pkg::OP_ENQ, 32'hAAAA_AAAA, 1, cqr_pkg::ST_OK, '0));
    dir_rows.push_back(row(cqr_pkg::OP_READOUT, '0, 0, cqr_pkg::ST_OK, '0));
    dir_rows.push_back(row(cqr_pkg::OP_DEQ, '0, 1, cqr_pkg::ST_OK, 32'h5555_5555));
    dir_rows.push_back(row(cqr_pkg::OP_ENQ, 32'h0000_0001, 1, cqr_pkg::ST_OK, '0));
    dir_rows.push_back(row(cqr_pkg::OP_READOUT, '0, 0, cqr_pkg::ST_OK, '0));
    dir_rows.push_back(row(cqr_pkg::OP_DEQ, '0, 0, cqr_pkg::ST_OK, '0));
    dir_rows.push_back(row(cqr_pkg::OP_DEQ, '0, 0, cqr_pkg::ST_OK, '0));
    dir_rows.push_back(row(cqr_pkg::OP_READOUT, '0, 1, cqr_pkg::ST_EMPTY, '0));

    // The capacity is lowered below the fill level after the first phase, and the
    // out-of-range values 0, 17 and 31 are clamped by the block.
    phase_cap = '{5'd16, 5'd3, 5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'($urandom_range(1, 16))};
    phase_bias = '{1, 2, 0, 0, 1, 2, 0, 0};
    phase_len = '{30, 25, 20, 20, 30, 25, 25, 25};
    phase_idle = '{1, 1, 1, 1, 0, 1, 1, 1};

    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_capacity(5'd16);
    for (i = 0; i < dir_rows.size(); i++) begin
      row_typed = dir_rows[i].typed;
      row_status = dir_rows[i].status;
      row_data = dir_rows[i].data;
      send_item(dir_rows[i].op, dir_rows[i].word, 1'b1);
    end
    row_typed = 1'b0;

    for (j = 0; j < 8; j++) begin
      write_capacity(phase_cap[j]);
      n = 0;
      while (n < phase_len[j]) begin
        op = random_op(phase_bias[j]);
        if (op != OP_UNUSED) n++;
        send_item(op, random_word(), phase_idle[j]);
        if (phase_idle[j] && $urandom_range(24) == 0) wait_results_drained(1'b0);
      end
    end

    wait_results_drained(1'b1);
    $display("Sent %0d queue operations and checked %0d results, over capacities 16, 3, 1,",
             items_sent, results_checked);
    $display("0, 31, 17, 5 and %0d, with overflow, underflow, wrap and empty readouts.",
             phase_cap[7]);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: circular_queue_with_readout_top.f
rtl/cqr_pkg.sv
rtl/cqr_slot_ram.sv
rtl/circular_queue_with_readout_top.sv
tb/tb.sv
